FILE: hdl/tmql_pkg.sv
`timescale 1ns / 1ps

package tmql_pkg;

    // Log store size; the marker count saturates at min(LOG_DEPTH, 255).
    localparam int LOG_DEPTH = 256;
    localparam int LOG_CAP   = (LOG_DEPTH > 255) ? 255 : LOG_DEPTH;

    localparam int DIST_W  = 24;
    localparam int LEN_W   = 16;
    localparam int COUNT_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_DIST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SEARCH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_READ   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPACING   = 3'd4;

    // Qualifier phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_CONFIRM = 2'd1;
    localparam logic [1:0] PH_WINDOW  = 2'd2;

    // Start side codes
    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;
    localparam logic [1:0] SIDE_BOTH  = 2'd3;

    // Event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_LEFT  = 2'd1;
    localparam logic [1:0] EV_RIGHT = 2'd2;
    localparam logic [1:0] EV_CROSS = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0] center_dist;
        logic [DIST_W-1:0] left_wheel_dist;
        logic [DIST_W-1:0] right_wheel_dist;
        logic              left_seen;
        logic              right_seen;
    } sample_t;

    typedef struct packed {
        logic [1:0]         marker_event;
        logic               log_valid;
        logic [7:0]         log_index;
        logic [DIST_W-1:0]  log_center;
        logic [DIST_W-1:0]  log_left;
        logic [DIST_W-1:0]  log_right;
        logic [COUNT_W-1:0] marker_total;
        logic               log_full;
    } result_t;

    typedef struct packed {
        logic             search_mode;
        logic [LEN_W-1:0] confirm_dist;
        logic [LEN_W-1:0] window_search;
        logic [LEN_W-1:0] window_read;
        logic [LEN_W-1:0] min_spacing;
    } cfg_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_write_t;

    typedef struct packed {
        logic [1:0]         phase;
        logic [1:0]         start_side;
        logic               cross_seen;
        logic [DIST_W-1:0]  base_dist;
        logic [DIST_W-1:0]  latched_left;
        logic [DIST_W-1:0]  latched_right;
        logic [DIST_W-1:0]  last_logged_center;
        logic [COUNT_W-1:0] marker_count;
    } qual_state_t;

endpackage

FILE: hdl/tmql_if.sv
`timescale 1ns / 1ps

interface tmql_sample_if;
    logic              valid;
    logic              ready;
    tmql_pkg::sample_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tmql_result_if;
    logic              valid;
    logic              ready;
    tmql_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tmql_cfg_if;
    logic                 valid;
    logic                 ready;
    tmql_pkg::cfg_write_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/tmql_step.sv
`timescale 1ns / 1ps

module tmql_step (
    input  tmql_pkg::qual_state_t state,
    input  tmql_pkg::cfg_t        cfg,
    input  tmql_pkg::sample_t     sample,
    output tmql_pkg::qual_state_t state_next,
    output tmql_pkg::result_t     result
);
    import tmql_pkg::*;

    // True when now - from > lim, taken as a signed difference.
    function automatic logic gone_past(input logic [DIST_W-1:0] now,
                                       input logic [DIST_W-1:0] from,
                                       input logic [LEN_W-1:0]  lim);
        logic [DIST_W:0] diff;
        diff = {1'b0, now} - {1'b0, from};
        return !diff[DIST_W] && (diff[DIST_W-1:0] > {{(DIST_W-LEN_W){1'b0}}, lim});
    endfunction

    logic             confirm_done;
    logic             window_done;
    logic             spacing_ok;
    logic             at_cap;
    logic             cross_now;
    logic             other_seen;
    logic [LEN_W-1:0] window_len;

    assign window_len   = cfg.search_mode ? cfg.window_search : cfg.window_read;
    assign confirm_done = gone_past(sample.center_dist, state.base_dist, cfg.confirm_dist);
    assign window_done  = gone_past(sample.center_dist, state.base_dist, window_len);
    assign spacing_ok   = gone_past(state.base_dist, state.last_logged_center,
                                    cfg.min_spacing);
    assign at_cap       = state.marker_count >= COUNT_W'(LOG_CAP);
    // A right start stays a right marker while the right sensor still sees it
    assign cross_now    = (state.start_side == SIDE_LEFT) ? sample.right_seen
                        : (sample.left_seen & ~sample.right_seen);
    assign other_seen   = (state.start_side == SIDE_LEFT) ? sample.right_seen
                                                          : sample.left_seen;

    always_comb
    begin
        state_next = state;
        result     = '0;

        case (state.phase)
            PH_CONFIRM:
            begin
                if (confirm_done)
                begin
                    if (state.start_side == SIDE_BOTH)
                    begin
                        result.marker_event = (sample.left_seen | sample.right_seen)
                                            ? EV_CROSS : EV_NONE;
                        state_next.phase = PH_IDLE;
                    end
                    else
                    begin
                        if (!cross_now)
                        begin
                            state_next.base_dist     = sample.center_dist;
                            state_next.latched_left  = sample.left_wheel_dist;
                            state_next.latched_right = sample.right_wheel_dist;
                        end
                        state_next.cross_seen = cross_now;
                        state_next.phase      = PH_WINDOW;
                    end
                end
            end
            PH_WINDOW:
            begin
                if (!window_done)
                begin
                    if (other_seen)
                    begin
                        state_next.cross_seen = 1'b1;
                    end
                end
                else
                begin
                    if (state.cross_seen)
                    begin
                        result.marker_event = EV_CROSS;
                    end
                    else
                    begin
                        result.marker_event = (state.start_side == SIDE_LEFT)
                                            ? EV_LEFT : EV_RIGHT;
                        if (cfg.search_mode && spacing_ok)
                        begin
                            if (at_cap)
                            begin
                                result.log_full = 1'b1;
                            end
                            else
                            begin
                                result.log_valid = 1'b1;
                                result.log_index = state.marker_count;
                                result.log_center = state.base_dist;
                                result.log_left   = state.latched_left;
                                result.log_right  = state.latched_right;
                                state_next.marker_count = state.marker_count + COUNT_W'(1);
                                state_next.last_logged_center = state.base_dist;
                            end
                        end
                    end
                    state_next.cross_seen = 1'b0;
                    state_next.phase      = PH_IDLE;
                end
            end
            default:
            begin
                // Idle and the unused code both look for a new marker
                state_next.phase = PH_IDLE;
                if (sample.left_seen || sample.right_seen)
                begin
                    state_next.start_side = (sample.left_seen && sample.right_seen)
                                          ? SIDE_BOTH
                                          : (sample.left_seen ? SIDE_LEFT : SIDE_RIGHT);
                    state_next.base_dist  = sample.center_dist;
                    state_next.cross_seen = 1'b0;
                    state_next.phase      = PH_CONFIRM;
                end
            end
        endcase

        result.marker_total = state_next.marker_count;
    end

endmodule

FILE: hdl/track_marker_qualifier_logger_core.sv
`timescale 1ns / 1ps
// Channel   Role   Payload                                                Transfer when
// -------   ----   ----------------------------------------------------   ---------------
// sample    sink   center/left/right distance, left_seen, right_seen      valid && ready
// result    source event, log entry fields, marker_total, log_full        valid && ready
// cfg       sink   register index (3 bit), write data (16 bit)            valid && ready
//
// One sample per cycle is accepted while result is not stalled; its result
// appears in the result register in the cycle after the transfer. The qualifier
// state and the result register are the only pipeline, so without stalls throughput is one item per clock.
// rst_n clears the qualifier state, the result valid and loads register defaults.
// A stall on result holds the result register and drops sample ready until taken.

module track_marker_qualifier_logger_core (
    input  logic                 clk,
    input  logic                 rst_n,
    tmql_sample_if.sink          sample,
    tmql_result_if.source        result,
    tmql_cfg_if.sink             cfg
);
    import tmql_pkg::*;

    // Configuration registers
    cfg_t        cfg_reg;
    cfg_t        cfg_next;

    // Qualifier state, advanced once per sample transfer
    qual_state_t state_reg;
    qual_state_t state_next;

    // Result register
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_data_reg;
    result_t     step_result;

    logic        sample_xfer;

    // Registers are always writable; the host must write only while the block is quiet; nothing enforces it
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.data.index)
                CFG_SEARCH_MODE:   cfg_next.search_mode   = cfg.data.value[0];
                CFG_CONFIRM_DIST:  cfg_next.confirm_dist  = cfg.data.value;
                CFG_WINDOW_SEARCH: cfg_next.window_search = cfg.data.value;
                CFG_WINDOW_READ:   cfg_next.window_read   = cfg.data.value;
                CFG_MIN_SPACING:   cfg_next.min_spacing   = cfg.data.value;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.search_mode   <= 1'b1;
            cfg_reg.confirm_dist  <= LEN_W'(100);
            cfg_reg.window_search <= LEN_W'(400);
            cfg_reg.window_read   <= LEN_W'(100);
            cfg_reg.min_spacing   <= LEN_W'(330);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept a new sample whenever the result register is empty or being drained
    assign sample.ready = !out_valid_reg || result.ready;
    assign sample_xfer  = sample.valid && sample.ready;

    tmql_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .sample     (sample.data),
        .state_next (state_next),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase              <= PH_IDLE;
            state_reg.start_side         <= SIDE_NONE;
            state_reg.cross_seen         <= 1'b0;
            state_reg.base_dist          <= '0;
            state_reg.latched_left       <= '0;
            state_reg.latched_right      <= '0;
            state_reg.last_logged_center <= '0;
            state_reg.marker_count       <= '0;
        end
        else if (sample_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // Load on a sample transfer, drop valid once the result is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (sample_xfer)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            out_data_reg <= step_result;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

FILE: hdl/tmql_checker.sv
`timescale 1ns / 1ps

module tmql_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input tmql_pkg::result_t out_data
);
    import tmql_pkg::*;

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Every sample transfer yields a result in the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("sample transfer without result");

    // A logged entry is the last one counted
    a_log_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.log_valid |->
            out_data.marker_total == out_data.log_index + 8'd1)
        else $error("log index and marker total disagree");

    // Only single-side markers are logged
    a_log_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.log_valid |->
            out_data.marker_event == EV_LEFT || out_data.marker_event == EV_RIGHT)
        else $error("log entry on a non single-side event");

    // A dropped marker writes no entry and only happens at capacity
    a_log_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.log_full |->
            !out_data.log_valid && out_data.marker_total == 8'(LOG_CAP))
        else $error("log full flagged below capacity");

endmodule

bind track_marker_qualifier_logger_core tmql_checker u_tmql_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

FILE: test/track_marker_qualifier_logger_core_tb.sv
`timescale 1ns / 1ps

module track_marker_qualifier_logger_core_tb;
    import tmql_pkg::*;

    // Cycles without any transfer on any channel before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off below.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 250;
    // Result register is one stage deep; the settle wait covers it.
    localparam int SETTLE_CYCLES = 3;
    localparam int SATURATION_MARKERS = 265;
    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REGISTER = 3'd7;

    logic clk;
    logic rst_n;

    tmql_sample_if sample_ch ();
    tmql_result_if result_ch ();
    tmql_cfg_if    cfg_ch ();

    track_marker_qualifier_logger_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Qualifier model state: register mirror plus the marker tracking state.
    // The register mirror follows cfg transfers as the block sees them.
    // ------------------------------------------------------------------
    cfg_t               regs;
    logic [1:0]         trk_phase;
    logic [1:0]         trk_side;
    logic               trk_cross;
    logic [DIST_W-1:0]  trk_base;
    logic [DIST_W-1:0]  trk_latch_left;
    logic [DIST_W-1:0]  trk_latch_right;
    logic [DIST_W-1:0]  trk_last_logged;
    logic [COUNT_W-1:0] trk_count;

    // Results the qualifier owes, oldest first.
    result_t qualified_results[$];

    int sent_count;
    int checked_count;
    int mismatches;
    int stall_cycles;

    // Traffic shaping, set per test.
    bit sender_gaps;
    bit receiver_stalls;
    int hold_cycles;
    int burst_left;

    // Running odometry for the track generator.
    logic [DIST_W-1:0] track_pos;
    logic [DIST_W-1:0] track_left;
    logic [DIST_W-1:0] track_right;

    // True distance comparison: no wrap, now may sit below from.
    function automatic logic past_limit(input logic [DIST_W-1:0] now,
                                        input logic [DIST_W-1:0] from,
                                        input logic [LEN_W-1:0]  lim);
        longint diff;
        diff = longint'(now) - longint'(from);
        return diff > longint'(lim);
    endfunction

    // Advance the qualifier by one sample and return the result it produces.
    function automatic result_t qualify_sample(input sample_t s);
        result_t          res;
        logic [LEN_W-1:0] win;
        logic             early_cross;
        logic             other_side;
        longint           gap;
        res = '0;
        case (trk_phase)
            PH_CONFIRM:
            begin
                if (past_limit(s.center_dist, trk_base, regs.confirm_dist))
                begin
                    if (trk_side == SIDE_BOTH)
                    begin
                        res.marker_event = (s.left_seen || s.right_seen) ? EV_CROSS : EV_NONE;
                        trk_phase = PH_IDLE;
                    end
                    else
                    begin
                        // A right start stays a right marker while its own sensor is still on.
                        early_cross = (trk_side == SIDE_LEFT) ? s.right_seen
                                                              : (s.left_seen & ~s.right_seen);
                        // Keep the start point on an early cross; otherwise latch here.
                        if (!early_cross)
                        begin
                            trk_base        = s.center_dist;
                            trk_latch_left  = s.left_wheel_dist;
                            trk_latch_right = s.right_wheel_dist;
                        end
                        trk_cross = early_cross;
                        trk_phase = PH_WINDOW;
                    end
                end
            end
            PH_WINDOW:
            begin
                win = regs.search_mode ? regs.window_search : regs.window_read;
                if (!past_limit(s.center_dist, trk_base, win))
                begin
                    other_side = (trk_side == SIDE_LEFT) ? s.right_seen : s.left_seen;
                    if (other_side)
                        trk_cross = 1'b1;
                end
                else
                begin
                    // The tick that leaves the window is not examined and starts nothing.
                    if (trk_cross)
                        res.marker_event = EV_CROSS;
                    else
                    begin
                        res.marker_event = (trk_side == SIDE_LEFT) ? EV_LEFT : EV_RIGHT;
                        gap = longint'(trk_base) - longint'(trk_last_logged);
                        if (regs.search_mode && gap > longint'(regs.min_spacing))
                        begin
                            if (int'(trk_count) >= LOG_CAP)
                                res.log_full = 1'b1;
                            else
                            begin
                                res.log_valid  = 1'b1;
                                res.log_index  = trk_count;
                                res.log_center = trk_base;
                                res.log_left   = trk_latch_left;
                                res.log_right  = trk_latch_right;
                                trk_count       = trk_count + COUNT_W'(1);
                                trk_last_logged = trk_base;
                            end
                        end
                    end
                    trk_cross = 1'b0;
                    trk_phase = PH_IDLE;
                end
            end
            default:
            begin
                trk_phase = PH_IDLE;
                if (s.left_seen || s.right_seen)
                begin
                    trk_side  = (s.left_seen && s.right_seen) ? SIDE_BOTH :
                                (s.left_seen ? SIDE_LEFT : SIDE_RIGHT);
                    trk_base  = s.center_dist;
                    trk_cross = 1'b0;
                    trk_phase = PH_CONFIRM;
                end
            end
        endcase
        res.marker_total = trk_count;
        return res;
    endfunction

    function automatic void apply_register(input cfg_write_t w);
        case (w.index)
            CFG_SEARCH_MODE:   regs.search_mode   = w.value[0];
            CFG_CONFIRM_DIST:  regs.confirm_dist  = w.value;
            CFG_WINDOW_SEARCH: regs.window_search = w.value;
            CFG_WINDOW_READ:   regs.window_read   = w.value;
            CFG_MIN_SPACING:   regs.min_spacing   = w.value;
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string field, input logic [DIST_W-1:0] want,
                                        input logic [DIST_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check result transfers against the oldest owed result,
    // follow register writes, and predict every accepted sample.
    // Checking comes first: a result can never belong to a sample taken
    // at the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (qualified_results.size() == 0)
                begin
                    $display("%0t: result with nothing owed, actual %p", $time, result_ch.data);
                    mismatches++;
                end
                else
                begin
                    want = qualified_results.pop_front();
                    checked_count++;
                    check_field("marker_event", DIST_W'(want.marker_event),
                                DIST_W'(result_ch.data.marker_event));
                    check_field("log_valid", DIST_W'(want.log_valid),
                                DIST_W'(result_ch.data.log_valid));
                    check_field("log_index", DIST_W'(want.log_index),
                                DIST_W'(result_ch.data.log_index));
                    check_field("log_center", want.log_center, result_ch.data.log_center);
                    check_field("log_left", want.log_left, result_ch.data.log_left);
                    check_field("log_right", want.log_right, result_ch.data.log_right);
                    check_field("marker_total", DIST_W'(want.marker_total),
                                DIST_W'(result_ch.data.marker_total));
                    check_field("log_full", DIST_W'(want.log_full),
                                DIST_W'(result_ch.data.log_full));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                apply_register(cfg_ch.data);
            if (sample_ch.valid && sample_ch.ready)
                qualified_results.push_back(qualify_sample(sample_ch.data));
        end
    end

    // Watchdog: count cycles with no transfer anywhere; bail out at the limit.
    initial
    begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: hold off when asked (counted here), otherwise stall on a
    // rotating random pattern, or take everything when stalls are off.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        logic [15:0] pattern;
        int          slot;
        result_ch.ready <= 1'b0;
        pattern = '1;
        slot = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (!receiver_stalls)
                result_ch.ready <= 1'b1;
            else
            begin
                result_ch.ready <= pattern[0];
                pattern = {pattern[0], pattern[15:1]};
                slot++;
                if (slot == 16)
                begin
                    // Bias toward ready: OR of two random words.
                    pattern = 16'($urandom) | 16'($urandom);
                    slot = 0;
                end
            end
        end
    end

    // Offer one sample and hold it until the transfer. Bursts of random
    // length with random gaps between them when gaps are on.
    task automatic send_sample(input logic [DIST_W-1:0] center, input logic [DIST_W-1:0] lw,
                               input logic [DIST_W-1:0] rw, input logic ls, input logic rs);
        sample_t s;
        int      gap;
        s.center_dist      = center;
        s.left_wheel_dist  = lw;
        s.right_wheel_dist = rw;
        s.left_seen        = ls;
        s.right_seen       = rs;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = sender_gaps ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= s;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        sent_count++;
    endtask

    // Sample with random wheel distances.
    task automatic send_at(input logic [DIST_W-1:0] center, input logic ls, input logic rs);
        send_sample(center, DIST_W'($urandom), DIST_W'($urandom), ls, rs);
    endtask

    // Drop valid and wait until every owed result has been taken, then settle.
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (checked_count < sent_count)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    // Write all five registers back to back, with an optional stray write, while the block is idle.
    task automatic set_config(input logic [15:0] mode_word, input logic [15:0] confirm,
                              input logic [15:0] win_search, input logic [15:0] win_read,
                              input logic [15:0] spacing, input bit stray);
        cfg_write_t writes[$];
        drain_results();
        writes.push_back({CFG_SEARCH_MODE, mode_word});
        writes.push_back({CFG_CONFIRM_DIST, confirm});
        if (stray)
            writes.push_back({CFG_NO_REGISTER, 16'hFFFF});
        writes.push_back({CFG_WINDOW_SEARCH, win_search});
        writes.push_back({CFG_WINDOW_READ, win_read});
        writes.push_back({CFG_MIN_SPACING, spacing});
        foreach (writes[i])
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= writes[i];
            do
                @(posedge clk);
            while (cfg_ch.ready !== 1'b1);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Track generator: forward motion with random steps, marker pulses on
    // each side, occasional joint pulses, and a little noise (jumps,
    // backward steps, random sensor bits).
    task automatic run_track(input int count, input int max_step, input int pulse_pct);
        int                n;
        int                roll;
        int                left_on;
        int                right_on;
        logic [DIST_W-1:0] step;
        logic              ls;
        logic              rs;
        left_on = 0;
        right_on = 0;
        for (n = 0; n < count; n++)
        begin
            step = DIST_W'($urandom_range(0, max_step));
            roll = $urandom_range(0, 99);
            if (roll < 2)
                track_pos = DIST_W'($urandom_range(0, 24'hBFFFFF));
            else if (roll < 4)
                track_pos = track_pos - step - DIST_W'(1);
            else
                track_pos = track_pos + step;
            track_left  = track_left + step + DIST_W'($urandom_range(0, 3));
            track_right = track_right + step + DIST_W'($urandom_range(0, 3));
            if (left_on == 0 && right_on == 0 && $urandom_range(0, 99) < 2)
            begin
                left_on = 2;
                right_on = 2;
            end
            if (left_on == 0 && $urandom_range(0, 99) < pulse_pct)
                left_on = $urandom_range(1, 4);
            if (right_on == 0 && $urandom_range(0, 99) < pulse_pct)
                right_on = $urandom_range(1, 4);
            ls = (left_on > 0);
            rs = (right_on > 0);
            if (left_on > 0)
                left_on--;
            if (right_on > 0)
                right_on--;
            if ($urandom_range(0, 99) < 2)
            begin
                ls = 1'($urandom_range(0, 1));
                rs = 1'($urandom_range(0, 1));
            end
            send_sample(track_pos, track_left, track_right, ls, rs);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Left marker under the reset register values: confirm 100, search window 400.
    task automatic test_reset_defaults();
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        send_at(24'd1000, 1'b1, 1'b0);
        send_at(24'd1101, 1'b0, 1'b0);
        send_at(24'd1502, 1'b0, 1'b0);
    endtask

    // Named corner cases with short distances (confirm 10, windows 20 / 50).
    task automatic test_directed_cases();
        set_config(16'h0001, 16'd10, 16'd20, 16'd50, 16'd5, 1'b1);
        // Both-side start at zero, confirmed at the top of the range with no sensor: nothing.
        send_sample(24'd0, 24'd0, 24'd0, 1'b1, 1'b1);
        send_sample(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0);
        // Both-side start with one sensor at confirm: cross.
        send_at(24'd2100, 1'b1, 1'b1);
        send_at(24'd2111, 1'b1, 1'b0);
        // Left start, right seen at confirm: cross, window counted from the start point.
        send_at(24'd2200, 1'b1, 1'b0);
        send_at(24'd2211, 1'b0, 1'b1);
        send_at(24'd2221, 1'b0, 1'b0);
        // Right start still lit at confirm stays right; left inside the window makes it cross.
        send_at(24'd2300, 1'b0, 1'b1);
        send_at(24'd2311, 1'b1, 1'b1);
        send_at(24'd2320, 1'b1, 1'b0);
        send_at(24'd2332, 1'b0, 1'b0);
        // Right start, left only at confirm: cross.
        send_at(24'd2400, 1'b0, 1'b1);
        send_at(24'd2411, 1'b1, 1'b0);
        send_at(24'd2421, 1'b0, 1'b0);
        // Window end with both sensors lit: ignored, left marker logged.
        send_at(24'd2500, 1'b1, 1'b0);
        send_at(24'd2511, 1'b0, 1'b0);
        send_at(24'd2532, 1'b1, 1'b1);
        // Marker behind the last logged one: negative spacing, not logged, not full.
        send_at(24'd10, 1'b1, 1'b0);
        send_at(24'd21, 1'b0, 1'b0);
        send_at(24'd42, 1'b0, 1'b0);
        // Switch to read mode mid-marker; the read window applies from here on.
        send_at(24'd2600, 1'b0, 1'b1);
        send_at(24'd2611, 1'b0, 1'b0);
        set_config(16'h0000, 16'd10, 16'd20, 16'd50, 16'd5, 1'b0);
        send_at(24'd2640, 1'b1, 1'b0);
        send_at(24'd2662, 1'b0, 1'b0);
    endtask

    // Random tracks over several register settings, extremes included.
    task automatic test_random_tracks();
        logic [15:0] word;
        track_pos   = DIST_W'($urandom_range(0, 24'h400000));
        track_left  = DIST_W'($urandom);
        track_right = DIST_W'($urandom);
        // Everything at zero, no idling on either side.
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        set_config(16'h0001, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        run_track(100, 3, 15);
        // Search run with the receiver holding off: the block fills and stalls.
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        set_config(16'hFFFF, 16'd30, 16'd120, 16'd40, 16'd250, 1'b0);
        hold_cycles = HOLD_OFF_CYCLES;
        run_track(100, 20, 4);
        // Read run.
        set_config(16'hFFFE, 16'd30, 16'd120, 16'd40, 16'd100, 1'b0);
        run_track(100, 20, 4);
        // All lengths at the top, both modes; big steps to get through them.
        set_config(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        run_track(50, 30000, 4);
        set_config(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        run_track(50, 30000, 4);
        // Random small settings.
        repeat (2)
        begin
            word = 16'($urandom);
            set_config(word, 16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                       16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)), 1'b0);
            run_track(60, 25, 5);
        end
    endtask

    // Shortest possible single-side markers in search mode until the log is full.
    task automatic test_log_saturation();
        logic [DIST_W-1:0] pos;
        logic              left_first;
        int                n;
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        set_config(16'h0001, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        // Start past anything still pending, then flush the qualifier to idle.
        pos = ((trk_last_logged > trk_base) ? trk_last_logged : trk_base) + DIST_W'(1);
        send_at(pos, 1'b0, 1'b0);
        pos = pos + DIST_W'(1);
        send_at(pos, 1'b0, 1'b0);
        for (n = 0; n < SATURATION_MARKERS; n++)
        begin
            pos = pos + DIST_W'($urandom_range(1, 3));
            left_first = 1'($urandom_range(0, 1));
            send_at(pos, left_first, !left_first);
            // Keep the other side dark at confirm so no cross.
            pos = pos + DIST_W'($urandom_range(1, 4));
            if (left_first)
                send_at(pos, 1'($urandom_range(0, 1)), 1'b0);
            else
                send_at(pos, 1'b0, 1'($urandom_range(0, 1)));
            pos = pos + DIST_W'($urandom_range(1, 4));
            send_at(pos, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        sample_ch.valid <= 1'b0;
        sample_ch.data  <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.data     <= '0;
        sent_count = 0;
        checked_count = 0;
        mismatches = 0;
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        hold_cycles = 0;
        burst_left = 0;
        regs.search_mode   = 1'b1;
        regs.confirm_dist  = 16'd100;
        regs.window_search = 16'd400;
        regs.window_read   = 16'd100;
        regs.min_spacing   = 16'd330;
        trk_phase       = PH_IDLE;
        trk_side        = SIDE_NONE;
        trk_cross       = 1'b0;
        trk_base        = '0;
        trk_latch_left  = '0;
        trk_latch_right = '0;
        trk_last_logged = '0;
        trk_count       = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_cases();
        test_random_tracks();
        test_log_saturation();
        drain_results();

        if (mismatches == 0 && qualified_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
